// ===== sv/sdss_pkg.sv =====
// Shared types, constants and the segment decoder for the seven-segment scan block.
package sdss_pkg;

  localparam int VALUE_W     = 28;
  localparam int MAG_W       = 27;
  localparam int DWELL_W     = 16;
  localparam int CODE_W      = 4;
  localparam int SEL_W       = 3;
  localparam int SEG_W       = 7;
  localparam int CODE_COUNT  = 8;
  localparam int DIGIT_COUNT = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 28'sd99999999;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = -28'sd9999999;
  localparam logic [MAG_W-1:0] MAG_CLAMP_POS = 27'd99999999;
  localparam logic [MAG_W-1:0] MAG_CLAMP_NEG = 27'd9999999;

  // Reciprocal of ten, scaled by 2^35; exact for any 32-bit dividend.
  localparam logic [31:0] RECIP10       = 32'hCCCCCCCD;
  localparam int          RECIP10_SHIFT = 35;

  localparam logic [CODE_W-1:0] CODE_MINUS = 4'd10;
  localparam logic [SEL_W-1:0]  LAST_STEP  = SEL_W'(CODE_COUNT - 1);
  localparam logic [SEL_W-1:0]  LAST_POS   = SEL_W'(DIGIT_COUNT - 1);
  localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd100;

  typedef struct packed {
    logic             is_load;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } sdss_item_t;

  typedef enum logic {
    BK_SCAN,
    BK_CONVERT
  } bk_state_t;

  function automatic logic [SEG_W-1:0] seg_lut(input logic [CODE_W-1:0] code);
    logic [SEG_W-1:0] seg;
    case (code)
      4'd0:       seg = 7'h3f;
      4'd1:       seg = 7'h06;
      4'd2:       seg = 7'h5b;
      4'd3:       seg = 7'h4f;
      4'd4:       seg = 7'h66;
      4'd5:       seg = 7'h6d;
      4'd6:       seg = 7'h7d;
      4'd7:       seg = 7'h07;
      4'd8:       seg = 7'h7f;
      4'd9:       seg = 7'h6f;
      CODE_MINUS: seg = 7'h40;
      default:    seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

// ===== sv/sdss_in_if.sv =====
// Input channel interface: item kind and the value to display.
interface sdss_in_if import sdss_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink (input valid, kind, value, output ready);
endinterface

// ===== sv/sdss_out_if.sv =====
// Result channel interface: digit select and segment pattern.
interface sdss_out_if import sdss_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SEL_W-1:0] digit_select;
  logic [SEG_W-1:0] segments;

  modport source (output valid, digit_select, segments, input ready);
  modport sink (input valid, digit_select, segments, output ready);
endinterface

// ===== sv/sdss_front.sv =====
// Front end: accepts transactions, classifies them and clamps loads to sign and magnitude.
module sdss_front import sdss_pkg::*; (
  sdss_in_if.sink    in_ch,
  output logic       push_valid,
  output sdss_item_t push_item,
  input  logic       push_ready
);

  logic signed [VALUE_W-1:0] v;
  logic        [VALUE_W-1:0] v_neg;

  assign v     = in_ch.value;
  assign v_neg = VALUE_W'(-v);

  always_comb begin
    push_item.is_load = in_ch.kind;
    if (v > VALUE_MAX) begin
      push_item.neg = 1'b0;
      push_item.mag = MAG_CLAMP_POS;
    end else if (v < VALUE_MIN) begin
      push_item.neg = 1'b1;
      push_item.mag = MAG_CLAMP_NEG;
    end else if (v < 0) begin
      push_item.neg = 1'b1;
      push_item.mag = v_neg[MAG_W-1:0];
    end else begin
      push_item.neg = 1'b0;
      push_item.mag = v[MAG_W-1:0];
    end
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

endmodule

// ===== sv/sdss_queue.sv =====
// Small first-in first-out queue of classified items between front and back.
module sdss_queue import sdss_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  input  sdss_item_t push_item,
  output logic       push_ready,
  output logic       pop_valid,
  output sdss_item_t pop_item,
  input  logic       pop_ready
);

  sdss_item_t        entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== sv/sdss_back.sv =====
// Back end: decimal conversion of loads, digit scan timing and the output register.
module sdss_back import sdss_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  input  sdss_item_t         pop_item,
  output logic               pop_ready,
  input  logic [DWELL_W-1:0] dwell_ticks,
  sdss_out_if.source         out_ch
);

  bk_state_t          state_r, state_nxt;
  logic [CODE_W-1:0]  codes_r [CODE_COUNT];
  logic [CODE_W-1:0]  codes_nxt [CODE_COUNT];
  logic [MAG_W-1:0]   conv_mag_r, conv_mag_nxt;
  logic               conv_neg_r, conv_neg_nxt;
  logic [SEL_W-1:0]   step_r, step_nxt;
  logic [SEL_W-1:0]   scan_r, scan_nxt;
  logic [DWELL_W-1:0] dwell_cnt_r, dwell_cnt_nxt;
  logic               blank_r, blank_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [SEL_W-1:0]   out_digit_r, out_digit_nxt;
  logic [SEG_W-1:0]   out_seg_r, out_seg_nxt;

  logic [58:0]        prod;
  logic [MAG_W-1:0]   quo;
  logic [MAG_W-1:0]   quo_x10;
  logic [MAG_W-1:0]   rem_full;
  logic               out_free;
  logic [DWELL_W:0]   dwell_inc;
  logic [DWELL_W:0]   limit;
  logic [SEL_W-1:0]   scan_wrap;

  // Divide the remaining magnitude by ten: reciprocal multiply, then the remainder.
  assign prod     = 59'(conv_mag_r) * 59'(RECIP10);
  assign quo      = MAG_W'(prod[58:RECIP10_SHIFT]);
  assign quo_x10  = (quo << 3) + (quo << 1);
  assign rem_full = conv_mag_r - quo_x10;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign dwell_inc = {1'b0, dwell_cnt_r} + (DWELL_W+1)'(1);
  assign limit     = (dwell_ticks == '0) ? (DWELL_W+1)'(1) : {1'b0, dwell_ticks};
  assign scan_wrap = (scan_r == LAST_POS) ? '0 : scan_r + SEL_W'(1);

  always_comb begin
    state_nxt     = state_r;
    codes_nxt     = codes_r;
    conv_mag_nxt  = conv_mag_r;
    conv_neg_nxt  = conv_neg_r;
    step_nxt      = step_r;
    scan_nxt      = scan_r;
    dwell_cnt_nxt = dwell_cnt_r;
    blank_nxt     = blank_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_digit_nxt = out_digit_r;
    out_seg_nxt   = out_seg_r;
    pop_ready     = 1'b0;
    case (state_r)
      BK_SCAN: begin
        if (pop_valid) begin
          if (pop_item.is_load) begin
            pop_ready    = 1'b1;
            conv_mag_nxt = pop_item.mag;
            conv_neg_nxt = pop_item.neg;
            step_nxt     = '0;
            state_nxt    = BK_CONVERT;
          end else if (out_free) begin
            pop_ready     = 1'b1;
            out_valid_nxt = 1'b1;
            out_digit_nxt = scan_r;
            if (blank_r) begin
              out_seg_nxt   = '0;
              blank_nxt     = 1'b0;
              dwell_cnt_nxt = '0;
              scan_nxt      = scan_wrap;
            end else begin
              out_seg_nxt = seg_lut(codes_r[scan_r]);
              if (dwell_inc >= limit) begin
                blank_nxt     = 1'b1;
                dwell_cnt_nxt = '0;
              end else begin
                dwell_cnt_nxt = dwell_inc[DWELL_W-1:0];
              end
            end
          end
        end
      end
      BK_CONVERT: begin
        if (step_r == LAST_STEP) begin
          // What is left after seven divisions is the eighth decimal digit.
          codes_nxt[step_r] = conv_neg_r ? CODE_MINUS : conv_mag_r[CODE_W-1:0];
          state_nxt         = BK_SCAN;
        end else begin
          codes_nxt[step_r] = rem_full[CODE_W-1:0];
          conv_mag_nxt      = quo;
          step_nxt          = step_r + SEL_W'(1);
        end
      end
      default: state_nxt = BK_SCAN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_SCAN;
      codes_r     <= '{default: '0};
      step_r      <= '0;
      scan_r      <= '0;
      dwell_cnt_r <= '0;
      blank_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      codes_r     <= codes_nxt;
      step_r      <= step_nxt;
      scan_r      <= scan_nxt;
      dwell_cnt_r <= dwell_cnt_nxt;
      blank_r     <= blank_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    conv_mag_r  <= conv_mag_nxt;
    conv_neg_r  <= conv_neg_nxt;
    out_digit_r <= out_digit_nxt;
    out_seg_r   <= out_seg_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.digit_select = out_digit_r;
  assign out_ch.segments     = out_seg_r;

endmodule

// ===== sv/signed_decimal_seven_segment_scan.sv =====
// Top level of the signed decimal seven-segment scan driver.
//
// This block drives an eight-digit multiplexed seven-segment display from a
// signed value. A load transaction clamps the value to -9999999..99999999 and
// converts it to decimal: positions 0 to 6 show the low seven digits of the
// magnitude, position 7 shows a minus sign for negative values and otherwise
// the eighth digit; leading zeros stay lit. A load produces no result. Each
// tick transaction produces one result transaction carrying the digit select
// and the segment pattern (bit 0 is segment a, bit 6 is segment g). A digit
// stays lit for dwell_ticks ticks (zero counts as one), then one blank tick
// follows on the same digit select, and the scan moves to the next digit,
// wrapping after digit 7. Ticks flow at one transaction per clock while each
// result is taken and no load is being converted. A tick passes through the
// two-entry queue into the output register, from which its result is taken.
// A load holds the back end while it leaves the queue, while seven steps
// each take one decimal digit from the shared divide-by-ten unit, and while
// a final step stores the eighth digit or the minus sign. During that time
// the front end keeps accepting transactions until the queue is full.
// dwell_ticks resets to 100; the user must write it through cfg_wr_en and
// cfg_wr_data only while the block is idle; the block does not enforce this.

module signed_decimal_seven_segment_scan import sdss_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  sdss_in_if.sink            in_ch,
  sdss_out_if.source         out_ch,
  input  logic               cfg_wr_en,
  input  logic [DWELL_W-1:0] cfg_wr_data
);

  logic [DWELL_W-1:0] dwell_ticks_r;

  logic       push_valid;
  sdss_item_t push_item;
  logic       push_ready;
  logic       pop_valid;
  sdss_item_t pop_item;
  logic       pop_ready;

  // The dwell register is the only configuration state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_ticks_r <= DWELL_RESET;
    end else if (cfg_wr_en) begin
      dwell_ticks_r <= cfg_wr_data;
    end
  end

  // The front end classifies each transaction and reduces loads to sign and
  // magnitude, so the back end never sees an out-of-range value.
  sdss_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  // The queue keeps the order of loads and ticks, so a tick that follows a
  // load always shows the newly converted digits.
  sdss_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  // The back end owns the digit codes, the scan counters and the output
  // register, which takes a new result while the old one is being taken.
  sdss_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_item    (pop_item),
    .pop_ready   (pop_ready),
    .dwell_ticks (dwell_ticks_r),
    .out_ch      (out_ch)
  );

endmodule
